// ===== rtl/core/ita_pkg.sv =====
// Shared types, codes and character tables for the integer to ASCII formatter.
package ita_pkg;

	// Format selector codes
	localparam logic [2:0] OP_SDEC = 3'd0;
	localparam logic [2:0] OP_UDEC = 3'd1;
	localparam logic [2:0] OP_HEXL = 3'd2;
	localparam logic [2:0] OP_HEXU = 3'd3;
	localparam logic [2:0] OP_PTR  = 3'd4;

	localparam int OP_W    = 3;
	localparam int VAL_W   = 64;
	localparam int CHAR_W  = 8;
	localparam int POS_W   = 5;
	localparam int CNT_W   = 5;   // digit count, up to 16
	localparam int BIN_W   = 32;  // binary operand of the decimal conversion
	localparam int BCD_W   = 40;  // ten decimal digits
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 16;

	localparam logic [CNT_W-1:0] NDIG_DEC = 5'd10;
	localparam logic [CNT_W-1:0] NDIG_HEX = 5'd8;
	localparam logic [CNT_W-1:0] NDIG_PTR = 5'd16;

	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

	// Commands from the sequencer to the digit unit
	typedef struct packed {
		logic load;    // take a new operand
		logic dabble;  // one add-3 and shift step of the binary to BCD conversion
		logic shift;   // drop the top digit
	} digit_cmd_t;

	// Map a digit to its ASCII character
	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
		logic [CHAR_W-1:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {4'd0, d};
		end else if (upper) begin
			c = 8'h37 + {4'd0, d};   // 'A' - 10
		end else begin
			c = 8'h57 + {4'd0, d};   // 'a' - 10
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/ita_digit_unit.sv =====
// Digit register with the shared shift/add-3 unit that builds and strips digits.
module ita_digit_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ita_pkg::digit_cmd_t       cmd,
	input  logic [ita_pkg::OP_W-1:0]  op,
	input  logic [ita_pkg::VAL_W-1:0] value,
	output logic [3:0]                top_digit,
	output logic [ita_pkg::CNT_W-1:0] digit_cnt
);
	import ita_pkg::*;

	logic [VAL_W-1:0] dig_q;     // digits, most significant nibble at the top
	logic [BIN_W-1:0] bin_q;     // binary operand shifted out during dabble
	logic [CNT_W-1:0] cnt_q;     // digits left
	logic [BCD_W-1:0] bcd_adj;
	logic [BIN_W-1:0] lo;
	logic [BIN_W-1:0] mag;

	assign lo  = value[BIN_W-1:0];
	assign mag = (op == OP_SDEC && lo[BIN_W-1]) ? (~lo + 32'd1) : lo;

	// Add 3 to every BCD digit of five or more
	always_comb begin
		for (int i = 0; i < BCD_W / 4; i++) begin
			if (dig_q[VAL_W-BCD_W+4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = dig_q[VAL_W-BCD_W+4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = dig_q[VAL_W-BCD_W+4*i +: 4];
			end
		end
	end

	// Load, convert and strip
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= mag;
			unique case (op)
				OP_HEXL, OP_HEXU: dig_q <= {lo, {(VAL_W-BIN_W){1'b0}}};
				OP_PTR:           dig_q <= value;
				default:          dig_q <= '0;
			endcase
		end else if (cmd.dabble) begin
			dig_q <= {bcd_adj[BCD_W-2:0], bin_q[BIN_W-1], {(VAL_W-BCD_W){1'b0}}};
			bin_q <= {bin_q[BIN_W-2:0], 1'b0};
		end else if (cmd.shift) begin
			dig_q <= {dig_q[VAL_W-5:0], 4'd0};
		end
	end

	// Track the number of digits left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			unique case (op)
				OP_HEXL, OP_HEXU: cnt_q <= NDIG_HEX;
				OP_PTR:           cnt_q <= NDIG_PTR;
				default:          cnt_q <= NDIG_DEC;
			endcase
		end else if (cmd.shift) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	assign top_digit = dig_q[VAL_W-1 -: 4];
	assign digit_cnt = cnt_q;

endmodule

// ===== rtl/core/ita_seq.sv =====
// Sequencer: steps the digit unit and drives the output word register.
module ita_seq (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [ita_pkg::OP_W-1:0]         in_op,
	input  logic                             in_neg,
	output ita_pkg::digit_cmd_t              cmd,
	input  logic [3:0]                       top_digit,
	input  logic [ita_pkg::CNT_W-1:0]        digit_cnt,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [ita_pkg::CHAR_W-1:0]       out_char,
	output logic [ita_pkg::POS_W-1:0]        out_pos,
	output logic                             out_last
);
	import ita_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DABBLE = 5'b00010,
		ST_STRIP  = 5'b00100,
		ST_PREFIX = 5'b01000,
		ST_DIGITS = 5'b10000
	} state_t;

	state_t            state_q;
	logic [OP_W-1:0]   op_q;
	logic              neg_q;
	logic [4:0]        step_q;    // dabble step count
	logic [1:0]        pfx_q;     // prefix characters sent
	logic [1:0]        pfx_need;
	logic [POS_W-1:0]  pos_q;     // position of the next character
	logic [POS_W-1:0]  opos_q;    // position of the character in the output word
	logic              ovalid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic              can_load;
	logic              accept;
	logic              strip_done;
	logic              emit_pfx;
	logic              emit_dig;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready && (in_op <= OP_PTR);
	assign can_load   = !ovalid_q || out_ready;
	assign strip_done = (digit_cnt <= 5'd1) || (top_digit != 4'd0);
	assign pfx_need   = (op_q == OP_PTR) ? 2'd2 : (neg_q ? 2'd1 : 2'd0);
	assign emit_pfx   = (state_q == ST_PREFIX) && (pfx_q < pfx_need) && can_load;
	assign emit_dig   = (state_q == ST_DIGITS) && can_load;

	// Drive the digit unit
	always_comb begin
		cmd.load   = accept;
		cmd.dabble = (state_q == ST_DABBLE);
		cmd.shift  = ((state_q == ST_STRIP) && !strip_done) || emit_dig;
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_SDEC;
			neg_q   <= 1'b0;
			step_q  <= '0;
			pfx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q   <= in_op;
						neg_q  <= in_neg;
						step_q <= '0;
						pfx_q  <= '0;
						state_q <= (in_op == OP_SDEC || in_op == OP_UDEC) ? ST_DABBLE
						                                                   : ST_STRIP;
					end
				end
				ST_DABBLE: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd31) begin
						state_q <= ST_STRIP;
					end
				end
				ST_STRIP: begin
					if (strip_done) begin
						state_q <= ST_PREFIX;
					end
				end
				ST_PREFIX: begin
					if (pfx_q >= pfx_need) begin
						state_q <= ST_DIGITS;
					end else if (emit_pfx) begin
						pfx_q <= pfx_q + 2'd1;
					end
				end
				ST_DIGITS: begin
					if (emit_dig && digit_cnt == 5'd1) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the output word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			pos_q    <= '0;
			opos_q   <= '0;
		end else begin
			if (accept) begin
				pos_q <= '0;
			end else if (emit_pfx || emit_dig) begin
				pos_q <= pos_q + 5'd1;
			end
			if (emit_pfx || emit_dig) begin
				ovalid_q <= 1'b1;
				opos_q   <= pos_q;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Load the output character
	always_ff @(posedge clk) begin
		if (emit_pfx) begin
			last_q <= 1'b0;
			if (op_q == OP_PTR) begin
				char_q <= (pfx_q == 2'd0) ? CH_ZERO : CH_X;
			end else begin
				char_q <= CH_MINUS;
			end
		end else if (emit_dig) begin
			char_q <= digit_char(top_digit, op_q == OP_HEXU);
			last_q <= (digit_cnt == 5'd1);
		end
	end

	assign out_valid = ovalid_q;
	assign out_char  = char_q;
	assign out_pos   = opos_q;
	assign out_last  = last_q;

endmodule

// ===== rtl/core/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter.
//
// Input channel (s_*): one word carries a format selector and a 64-bit number.
// Formats: signed decimal, unsigned decimal, lower hex, upper hex (low 32 bits)
// and a 64-bit pointer printed as 0x plus lower hex. Unused selectors are
// consumed and produce nothing.
// Output channel (m_*): one word per character, most significant first, with
// its position in the run; m_tlast marks the final character.
// Decimal formats run 32 binary-to-BCD steps, then drop leading zeros
// one digit per cycle (up to 9), then send one character per cycle while
// the receiver is ready. Hex formats skip the conversion.
// The digit unit does a single shift/add-3 step per cycle.
// s_tready is high only while the block is idle; one number is in work at a time.
// A stalled receiver holds the output word and halts character generation.
// Reset clears the sequencer and the output valid; the block is idle after it.
module integer_to_ascii_formatter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [ita_pkg::IN_TDATA_W-1:0]      s_tdata,   // op[2:0], value[66:3], zero fill
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [ita_pkg::OUT_TDATA_W-1:0]     m_tdata,   // char_out[7:0], position[12:8], zero fill
	output logic                                m_tlast
);
	import ita_pkg::*;

	logic [OP_W-1:0]   op;
	logic [VAL_W-1:0]  value;
	logic              neg;
	digit_cmd_t        cmd;
	logic [3:0]        top_digit;
	logic [CNT_W-1:0]  digit_cnt;
	logic [CHAR_W-1:0] char_out;
	logic [POS_W-1:0]  position;

	// Unpack the input word
	assign op    = s_tdata[OP_W-1:0];
	assign value = s_tdata[OP_W +: VAL_W];
	assign neg   = (op == OP_SDEC) && value[BIN_W-1];

	ita_digit_unit u_digit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.op        (op),
		.value     (value),
		.top_digit (top_digit),
		.digit_cnt (digit_cnt)
	);

	ita_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (op),
		.in_neg    (neg),
		.cmd       (cmd),
		.top_digit (top_digit),
		.digit_cnt (digit_cnt),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (char_out),
		.out_pos   (position),
		.out_last  (m_tlast)
	);

	// Pack the output word
	assign m_tdata = {{(OUT_TDATA_W-CHAR_W-POS_W){1'b0}}, position, char_out};

endmodule

// ===== verif/integer_to_ascii_formatter_test.sv =====
// Self-checking testbench for the integer to ASCII formatter stream block.
module integer_to_ascii_formatter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ita_pkg::*;

	// Selector codes that the block consumes without output
	localparam logic [2:0] OP_RSVD5 = 3'd5;
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;

	localparam int RANDOM_ITEMS = 270;
	localparam int CALM_FROM    = 235;
	localparam int PAUSE_AT     = 130;
	localparam int DRAIN_CYCLES = 80;

	typedef struct {
		logic [CHAR_W-1:0] code;
		logic [POS_W-1:0]  pos;
		logic              is_last;
	} ascii_char_t;

	typedef struct {
		logic [OP_W-1:0]  op;
		logic [VAL_W-1:0] value;
		bit               typed;   // text below holds the expected characters
		string            text;
	} stim_row_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;

	ascii_char_t expected_chars[$];
	int          errors        = 0;
	int          chars_checked = 0;
	int          runs_seen     = 0;
	int          per_op[8]     = '{default: 0};
	bit          calm          = 1'b0;

	// Directed stimulus: extremes of each format, ignored high bits, unused selectors
	stim_row_t directed_rows[$] = '{
		'{OP_SDEC, 64'h0000_0000_0000_0000, 1'b1, "0"},
		'{OP_SDEC, 64'h0000_0000_7FFF_FFFF, 1'b1, "2147483647"},
		'{OP_SDEC, 64'h0000_0000_8000_0000, 1'b1, "-2147483648"},
		'{OP_SDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "-1"},
		'{OP_SDEC, 64'hFFFF_FFFF_0000_002A, 1'b1, "42"},
		'{OP_SDEC, 64'h0000_0000_8000_0001, 1'b0, ""},
		'{OP_UDEC, 64'h0000_0000_0000_0000, 1'b1, "0"},
		'{OP_UDEC, 64'h0000_0000_FFFF_FFFF, 1'b1, "4294967295"},
		'{OP_UDEC, 64'h0000_0000_8000_0000, 1'b1, "2147483648"},
		'{OP_UDEC, 64'h5555_5555_0000_0009, 1'b1, "9"},
		'{OP_UDEC, 64'h0000_0000_0000_000A, 1'b1, "10"},
		'{OP_UDEC, 64'hAAAA_AAAA_1234_5678, 1'b0, ""},
		'{OP_HEXL, 64'h0000_0000_0000_0000, 1'b1, "0"},
		'{OP_HEXL, 64'h0000_0000_FFFF_FFFF, 1'b1, "ffffffff"},
		'{OP_HEXL, 64'hDEAD_BEEF_0000_ABCD, 1'b1, "abcd"},
		'{OP_HEXU, 64'h0000_0000_FFFF_FFFF, 1'b1, "FFFFFFFF"},
		'{OP_HEXU, 64'hFFFF_FFFF_89AB_CDEF, 1'b1, "89ABCDEF"},
		'{OP_PTR,  64'h0000_0000_0000_0000, 1'b1, "0x0"},
		'{OP_PTR,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "0xffffffffffffffff"},
		'{OP_PTR,  64'h8000_0000_0000_0000, 1'b1, "0x8000000000000000"},
		'{OP_PTR,  64'h0123_4567_89AB_CDEF, 1'b0, ""},
		'{OP_RSVD5, 64'h0000_0000_0000_1234, 1'b1, ""},
		'{OP_RSVD6, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ""},
		'{OP_RSVD7, 64'h0000_0000_0000_0000, 1'b1, ""}
	};

	integer_to_ascii_formatter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Queue one run of characters, numbering them and flagging the last
	function automatic void queue_run(input byte unsigned run[$]);
		ascii_char_t c;
		for (int k = 0; k < run.size(); k++) begin
			c.code    = run[k];
			c.pos     = k[POS_W-1:0];
			c.is_last = (k == run.size() - 1);
			expected_chars.push_back(c);
		end
	endfunction

	// Work out the text of one number in the selected format
	function automatic void predict_text(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value);
		byte unsigned text[$];
		byte unsigned digits[$];
		logic [63:0]  mag;
		logic [63:0]  base;
		logic [3:0]   d;
		logic         upper;
		upper = 1'b0;
		base  = 64'd16;
		mag   = {32'd0, value[31:0]};
		case (op)
			OP_SDEC: begin
				base = 64'd10;
				if (value[31]) begin
					text.push_back("-");
					mag = {32'd0, -value[31:0]};
				end
			end
			OP_UDEC: begin
				base = 64'd10;
			end
			OP_HEXL: begin
			end
			OP_HEXU: begin
				upper = 1'b1;
			end
			OP_PTR: begin
				text.push_back("0");
				text.push_back("x");
				mag = value;
			end
			default: begin
				return;
			end
		endcase
		// Peel digits off the low end, building the text back to front
		do begin
			d = 4'(mag % base);
			if (d < 4'd10) begin
				digits.push_front(CH_ZERO + {4'd0, d});
			end else begin
				digits.push_front((upper ? 8'h41 : 8'h61) + {4'd0, d} - 8'd10);
			end
			mag = mag / base;
		end while (mag != 64'd0);
		foreach (digits[i]) text.push_back(digits[i]);
		queue_run(text);
	endfunction

	// Random number with a spread of lengths and the interesting boundaries
	function automatic logic [VAL_W-1:0] pick_value();
		logic [VAL_W-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: begin
			end
			1: v = v >> $urandom_range(0, 63);
			2: v[31:0] = $urandom_range(0, 20);
			3: begin
				case ($urandom_range(0, 5))
					0: v[31:0] = 32'h7FFF_FFFF;
					1: v[31:0] = 32'h8000_0000;
					2: v[31:0] = 32'hFFFF_FFFF;
					3: v[31:0] = 32'h8000_0001;
					4: v[31:0] = 32'd999_999_999;
					default: v[31:0] = 32'd1_000_000_000;
				endcase
			end
			4: v[31:0] = v[31:0] >> $urandom_range(0, 31);
			default: v = 64'd1 << $urandom_range(0, 63);
		endcase
		return v;
	endfunction

	// Offer one word and hold it until the block takes it
	task automatic send_word(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W - OP_W - VAL_W){1'b0}}, value, op};
		do @(posedge clk); while (!s_tready);
		per_op[op]++;
	endtask

	// Drop valid for a number of cycles, with junk on the data lines
	task automatic rest_sender(input int cycles);
		@(negedge clk);
		s_tvalid <= 1'b0;
		s_tdata  <= IN_TDATA_W'({$urandom, $urandom, $urandom});
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Receiver: stall in bursts, with the stall rate changing every window
	initial begin : receiver
		int stall_left;
		int odds;
		int window;
		stall_left = 0;
		odds       = 0;
		window     = 0;
		forever begin
			@(negedge clk);
			if (window == 0) begin
				window = 64;
				case ($urandom_range(0, 2))
					0: odds = 0;
					1: odds = 4;
					default: odds = 12;
				endcase
			end
			window--;
			if (calm) begin
				stall_left = 0;
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (odds != 0 && $urandom_range(1, odds) == 1) begin
				stall_left = $urandom_range(1, 9) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare every accepted character word with the oldest expectation
	always @(posedge clk) begin : char_check
		ascii_char_t want;
		if (arst_n && m_tvalid && m_tready) begin
			chars_checked++;
			if (m_tlast) runs_seen++;
			if (expected_chars.size() == 0) begin
				$error("char_out: nothing expected, got %h at position %0d", m_tdata[7:0],
					m_tdata[12:8]);
				errors++;
			end else begin
				want = expected_chars.pop_front();
				if (m_tdata[7:0] !== want.code) begin
					$error("char_out: expected %h, got %h", want.code, m_tdata[7:0]);
					errors++;
				end
				if (m_tdata[12:8] !== want.pos) begin
					$error("position: expected %0d, got %0d", want.pos, m_tdata[12:8]);
					errors++;
				end
				if (m_tlast !== want.is_last) begin
					$error("last: expected %b, got %b", want.is_last, m_tlast);
					errors++;
				end
			end
		end
	end

	// Give up if the run hangs
	initial begin : watchdog
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		byte unsigned     run[$];
		logic [OP_W-1:0]  op;
		logic [VAL_W-1:0] value;
		int               counted;
		int               gap_odds;
		counted  = 0;
		gap_odds = 0;

		// Hold reset, then release it away from the clock edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed rows
		foreach (directed_rows[r]) begin
			send_word(directed_rows[r].op, directed_rows[r].value);
			if (directed_rows[r].typed) begin
				run.delete();
				for (int i = 0; i < directed_rows[r].text.len(); i++) begin
					run.push_back(directed_rows[r].text[i]);
				end
				queue_run(run);
			end else begin
				predict_text(directed_rows[r].op, directed_rows[r].value);
			end
			if ($urandom_range(0, 2) == 0) rest_sender($urandom_range(1, 9));
		end

		// Random numbers; unused selectors are sprinkled in but not counted
		while (counted < RANDOM_ITEMS) begin
			if (counted % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: gap_odds = 0;
					1: gap_odds = 3;
					default: gap_odds = 8;
				endcase
			end
			if ($urandom_range(0, 19) == 0) begin
				op = OP_W'($urandom_range(OP_RSVD5, OP_RSVD7));
			end else begin
				op = OP_W'($urandom_range(OP_SDEC, OP_PTR));
			end
			value = pick_value();
			send_word(op, value);
			predict_text(op, value);
			if (op <= OP_PTR) begin
				counted++;
			end
			calm = (counted >= CALM_FROM);

			// Hold off once until the output side has drained
			if (counted == PAUSE_AT && op <= OP_PTR) begin
				rest_sender(1);
				while (expected_chars.size() != 0) @(posedge clk);
			end else if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
				rest_sender($urandom_range(1, 9));
			end
		end

		// Drain, then allow for any late spurious word
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Formatted %0d numbers (sdec %0d, udec %0d, hexl %0d, hexu %0d, ptr %0d)",
			per_op[OP_SDEC] + per_op[OP_UDEC] + per_op[OP_HEXL] + per_op[OP_HEXU] + per_op[OP_PTR],
			per_op[OP_SDEC], per_op[OP_UDEC], per_op[OP_HEXL], per_op[OP_HEXU], per_op[OP_PTR]);
		$display("plus %0d unused selectors; %0d characters in %0d runs checked",
			per_op[OP_RSVD5] + per_op[OP_RSVD6] + per_op[OP_RSVD7], chars_checked, runs_seen);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/ita_pkg.sv
rtl/core/ita_digit_unit.sv
rtl/core/ita_seq.sv
rtl/core/integer_to_ascii_formatter.sv
verif/integer_to_ascii_formatter_test.sv
